/* hw/rtl/mbfe_pkg.sv */
// shared types and constants of the mirror border frame expander
// used by the register file, controller, datapath and top level; no dependencies
`default_nettype none

package mbfe_pkg;

   localparam int POS_W      = 10;
   localparam int PIX_W      = 8;
   localparam int ROW_CFG_W  = 9;
   localparam int COL_CFG_W  = 10;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // register indexes, decoded from paddr[3:2]
   localparam logic [1:0] REG_FIRST_ROW = 2'd0;
   localparam logic [1:0] REG_LAST_ROW  = 2'd1;
   localparam logic [1:0] REG_FIRST_COL = 2'd2;
   localparam logic [1:0] REG_LAST_COL  = 2'd3;

   localparam logic [ROW_CFG_W-1:0] RST_FIRST_ROW = 9'd1;
   localparam logic [ROW_CFG_W-1:0] RST_LAST_ROW  = 9'd479;
   localparam logic [COL_CFG_W-1:0] RST_FIRST_COL = 10'd1;
   localparam logic [COL_CFG_W-1:0] RST_LAST_COL  = 10'd639;

   typedef struct packed {
      logic [ROW_CFG_W-1:0] first_row;
      logic [ROW_CFG_W-1:0] last_row;
      logic [COL_CFG_W-1:0] first_col;
      logic [COL_CFG_W-1:0] last_col;
   } crop_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FOLD_PREP,
      ST_FOLD_STEP,
      ST_FOLD_FIN,
      ST_OOR,
      ST_ADDR,
      ST_MEM,
      ST_RDATA
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic fold_prep;
      logic fold_step;
      logic fold_fin;
      logic fold_col;
      logic fold_crop;
      logic addr_calc;
      logic mem_write;
      logic mem_read;
      logic out_load;
      logic out_oor;
   } dp_cmd_type;

   typedef struct packed {
      logic is_read;
      logic in_src;
      logic in_exp;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/mbfe_csr.sv */
// crop window register file behind the apb-style configuration port
// depends on mbfe_pkg for register indexes, reset values and the crop struct
`default_nettype none

module mbfe_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [mbfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [mbfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mbfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output mbfe_pkg::crop_cfg_type           crop
);

   logic [mbfe_pkg::ROW_CFG_W-1:0] first_row_ff;
   logic [mbfe_pkg::ROW_CFG_W-1:0] last_row_ff;
   logic [mbfe_pkg::COL_CFG_W-1:0] first_col_ff;
   logic [mbfe_pkg::COL_CFG_W-1:0] last_col_ff;
   logic [1:0]                     reg_idx;
   logic                           wr_en;

   assign reg_idx    = csr_paddr[mbfe_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff <= mbfe_pkg::RST_FIRST_ROW;
         last_row_ff  <= mbfe_pkg::RST_LAST_ROW;
         first_col_ff <= mbfe_pkg::RST_FIRST_COL;
         last_col_ff  <= mbfe_pkg::RST_LAST_COL;
      end else if (wr_en) begin
         unique case (reg_idx)
            mbfe_pkg::REG_FIRST_ROW: first_row_ff <= csr_pwdata[mbfe_pkg::ROW_CFG_W-1:0];
            mbfe_pkg::REG_LAST_ROW:  last_row_ff  <= csr_pwdata[mbfe_pkg::ROW_CFG_W-1:0];
            mbfe_pkg::REG_FIRST_COL: first_col_ff <= csr_pwdata[mbfe_pkg::COL_CFG_W-1:0];
            mbfe_pkg::REG_LAST_COL:  last_col_ff  <= csr_pwdata[mbfe_pkg::COL_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mbfe_pkg::REG_FIRST_ROW: csr_prdata = mbfe_pkg::CSR_DATA_W'(first_row_ff);
         mbfe_pkg::REG_LAST_ROW:  csr_prdata = mbfe_pkg::CSR_DATA_W'(last_row_ff);
         mbfe_pkg::REG_FIRST_COL: csr_prdata = mbfe_pkg::CSR_DATA_W'(first_col_ff);
         mbfe_pkg::REG_LAST_COL:  csr_prdata = mbfe_pkg::CSR_DATA_W'(last_col_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign crop.first_row = first_row_ff;
   assign crop.last_row  = last_row_ff;
   assign crop.first_col = first_col_ff;
   assign crop.last_col  = last_col_ff;

endmodule

`default_nettype wire

/* hw/rtl/mbfe_ctrl.sv */
// controller state machine: sequences capture, four mirror folds, address and memory access
// depends on mbfe_pkg for the state enum and the command and status structs
`default_nettype none

module mbfe_ctrl #(
   parameter int STEPS = 11
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  mbfe_pkg::dp_status_type  status,
   output mbfe_pkg::dp_cmd_type     cmd
);

   localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

   mbfe_pkg::ctrl_state_type state_ff, state_in;
   logic [SW-1:0]            cnt_ff, cnt_in;
   logic [1:0]               pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbfe_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbfe_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mbfe_pkg::ST_CHECK;
         end
         mbfe_pkg::ST_CHECK: begin
            if (status.is_read) begin
               state_in = status.in_exp ? mbfe_pkg::ST_FOLD_PREP : mbfe_pkg::ST_OOR;
            end else begin
               state_in = status.in_src ? mbfe_pkg::ST_ADDR : mbfe_pkg::ST_IDLE;
            end
         end
         mbfe_pkg::ST_FOLD_PREP: state_in = mbfe_pkg::ST_FOLD_STEP;
         mbfe_pkg::ST_FOLD_STEP: begin
            if (cnt_ff == '0) state_in = mbfe_pkg::ST_FOLD_FIN;
         end
         mbfe_pkg::ST_FOLD_FIN: begin
            state_in = (&pass_ff) ? mbfe_pkg::ST_ADDR : mbfe_pkg::ST_FOLD_PREP;
         end
         mbfe_pkg::ST_OOR: begin
            if (status.out_free) state_in = mbfe_pkg::ST_IDLE;
         end
         mbfe_pkg::ST_ADDR: state_in = mbfe_pkg::ST_MEM;
         mbfe_pkg::ST_MEM: begin
            state_in = status.is_read ? mbfe_pkg::ST_RDATA : mbfe_pkg::ST_IDLE;
         end
         mbfe_pkg::ST_RDATA: begin
            if (status.out_free) state_in = mbfe_pkg::ST_IDLE;
         end
         default: state_in = mbfe_pkg::ST_IDLE;
      endcase
   end

   // bit counter of the remainder loop and fold pass index
   // pass order: row source fold, row crop fold, col source fold, col crop fold
   always_comb begin
      cnt_in  = cnt_ff;
      pass_in = pass_ff;
      if (state_ff == mbfe_pkg::ST_CHECK) pass_in = '0;
      if (state_ff == mbfe_pkg::ST_FOLD_FIN) pass_in = pass_ff + 2'd1;
      if (state_ff == mbfe_pkg::ST_FOLD_PREP) cnt_in = SW'(STEPS - 1);
      if (state_ff == mbfe_pkg::ST_FOLD_STEP) cnt_in = cnt_ff - SW'(1);
   end

   // outputs
   always_comb begin
      cmd           = '0;
      req_tready    = 1'b0;
      cmd.fold_col  = pass_ff[1];
      cmd.fold_crop = pass_ff[0];
      unique case (state_ff)
         mbfe_pkg::ST_IDLE: begin
            // no transaction is taken while reset is held
            req_tready  = ~reset;
            cmd.capture = req_tvalid & ~reset;
         end
         mbfe_pkg::ST_CHECK:     ;
         mbfe_pkg::ST_FOLD_PREP: cmd.fold_prep = 1'b1;
         mbfe_pkg::ST_FOLD_STEP: cmd.fold_step = 1'b1;
         mbfe_pkg::ST_FOLD_FIN:  cmd.fold_fin  = 1'b1;
         mbfe_pkg::ST_OOR:       cmd.out_oor   = status.out_free;
         mbfe_pkg::ST_ADDR:      cmd.addr_calc = 1'b1;
         mbfe_pkg::ST_MEM: begin
            cmd.mem_write = ~status.is_read;
            cmd.mem_read  = status.is_read;
         end
         mbfe_pkg::ST_RDATA:     cmd.out_load  = status.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/mbfe_datapath.sv */
// datapath: item capture, crop clamping, shared mirror fold unit, frame store and result register
// depends on mbfe_pkg for field widths and the command, status and crop structs
`default_nettype none

module mbfe_datapath #(
   parameter int SRC_WIDTH  = 640,
   parameter int SRC_HEIGHT = 480,
   parameter int BORDER     = 100,
   parameter int CW         = 11
) (
   input  wire                                clock,
   input  wire                                reset,
   input  mbfe_pkg::dp_cmd_type               cmd,
   output mbfe_pkg::dp_status_type            status,
   input  mbfe_pkg::crop_cfg_type             crop,
   input  wire  [mbfe_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire  [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [mbfe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                         rsp_tuser
);

   localparam int PW    = mbfe_pkg::POS_W;
   localparam int XW    = mbfe_pkg::PIX_W;
   localparam int RW    = CW + 2;
   localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [CW-1:0] W_C   = CW'(SRC_WIDTH);
   localparam logic [CW-1:0] H_C   = CW'(SRC_HEIGHT);
   localparam logic [CW-1:0] W_M1  = CW'(SRC_WIDTH - 1);
   localparam logic [CW-1:0] H_M1  = CW'(SRC_HEIGHT - 1);
   localparam logic [CW-1:0] EXP_W = CW'(SRC_WIDTH + 2 * BORDER);
   localparam logic [CW-1:0] EXP_H = CW'(SRC_HEIGHT + 2 * BORDER);
   localparam logic [CW-1:0] B_C   = CW'(BORDER);

   logic [2*XW-1:0] mem [DEPTH];

   logic            op_ff;
   logic [CW-1:0]   col_ff, row_ff;
   logic [XW-1:0]   tv_ff, ir_ff;

   logic [CW-1:0]   frow_cl_ff, lrow_cl_ff, fcol_cl_ff, lcol_cl_ff;
   logic [CW-1:0]   row_lo_ff, row_len_ff, col_lo_ff, col_len_ff;

   logic [CW-1:0]   x_sel, center, base_in, len_in, d_in;
   logic [CW-1:0]   d_sh_ff, base_ff, len_ff;
   logic [RW-1:0]   rem_ff, per_ff, rem_sh, rem_in, refl;
   logic [CW-1:0]   fold_res;

   logic [AW-1:0]   addr_ff;
   logic [2*XW-1:0] rd_ff;

   logic            out_valid_ff, out_oor_ff;
   logic [XW-1:0]   out_tv_ff, out_ir_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser[0];
         col_ff <= CW'(req_tdata[PW-1:0]);
         row_ff <= CW'(req_tdata[2*PW-1:PW]);
         tv_ff  <= req_tdata[2*PW+XW-1:2*PW];
         ir_ff  <= req_tdata[2*PW+2*XW-1:2*PW+XW];
      end else if (cmd.fold_fin) begin
         if (cmd.fold_col) col_ff <= fold_res;
         else              row_ff <= fold_res;
      end
   end

   // crop window: clamp to the source, then collapse an inverted window to its first line
   always_ff @(posedge clock) begin
      frow_cl_ff <= (CW'(crop.first_row) > H_M1) ? H_M1 : CW'(crop.first_row);
      lrow_cl_ff <= (CW'(crop.last_row)  > H_M1) ? H_M1 : CW'(crop.last_row);
      fcol_cl_ff <= (CW'(crop.first_col) > W_M1) ? W_M1 : CW'(crop.first_col);
      lcol_cl_ff <= (CW'(crop.last_col)  > W_M1) ? W_M1 : CW'(crop.last_col);
      row_lo_ff  <= frow_cl_ff;
      col_lo_ff  <= fcol_cl_ff;
      row_len_ff <= (frow_cl_ff > lrow_cl_ff) ? CW'(1) : lrow_cl_ff - frow_cl_ff + CW'(1);
      col_len_ff <= (fcol_cl_ff > lcol_cl_ff) ? CW'(1) : lcol_cl_ff - fcol_cl_ff + CW'(1);
   end

   // fold setup: source fold mirrors around BORDER into [0, size-1],
   // crop fold mirrors around the window start into the window
   always_comb begin
      x_sel   = cmd.fold_col ? col_ff : row_ff;
      if (cmd.fold_crop) begin
         center = cmd.fold_col ? col_lo_ff  : row_lo_ff;
         len_in = cmd.fold_col ? col_len_ff : row_len_ff;
      end else begin
         center = B_C;
         len_in = cmd.fold_col ? W_C : H_C;
      end
      base_in = cmd.fold_crop ? center : '0;
      // a point below the start mirrors onto the same distance above it
      d_in    = (x_sel >= center) ? x_sel - center : center - CW'(1) - x_sel;
   end

   // restoring remainder loop, one bit of the distance per cycle
   assign rem_sh = {rem_ff[RW-2:0], d_sh_ff[CW-1]};
   assign rem_in = (rem_sh >= per_ff) ? rem_sh - per_ff : rem_sh;
   assign refl   = (rem_ff < RW'(len_ff)) ? rem_ff : per_ff - RW'(1) - rem_ff;
   assign fold_res = base_ff + refl[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.fold_prep) begin
         d_sh_ff <= d_in;
         rem_ff  <= '0;
         per_ff  <= RW'(len_in) << 1;
         len_ff  <= len_in;
         base_ff <= base_in;
      end else if (cmd.fold_step) begin
         d_sh_ff <= d_sh_ff << 1;
         rem_ff  <= rem_in;
      end
   end

   // frame store, tv in the low byte and ir in the high byte
   always_ff @(posedge clock) begin
      if (cmd.addr_calc) addr_ff <= AW'(row_ff * SRC_WIDTH + col_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) mem[addr_ff] <= {ir_ff, tv_ff};
      if (cmd.mem_read)  rd_ff <= mem[addr_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_oor) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_tv_ff  <= rd_ff[XW-1:0];
         out_ir_ff  <= rd_ff[2*XW-1:XW];
         out_oor_ff <= 1'b0;
      end else if (cmd.out_oor) begin
         out_tv_ff  <= '0;
         out_ir_ff  <= '0;
         out_oor_ff <= 1'b1;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_ir_ff, out_tv_ff};
   assign rsp_tuser[0] = out_oor_ff;

   assign status.is_read  = op_ff;
   assign status.in_src   = (col_ff < W_C) && (row_ff < H_C);
   assign status.in_exp   = (col_ff < EXP_W) && (row_ff < EXP_H);
   assign status.out_free = ~out_valid_ff | rsp_tready;

endmodule

`default_nettype wire

/* hw/rtl/mirror_border_frame_expander.sv */
// mirror border frame expander: a store passes the check, address and memory states before the next
// accept (only the check if outside the source frame); a read passes the check, four folds, address,
// memory and result states, then takes the next item, an out-of-frame read the check and result states;
// CW = max(10, clog2(2*max(SRC_WIDTH,SRC_HEIGHT)+2*BORDER+1)), one remainder bit per cycle
// in the shared fold unit, four folds a read; a pending result stalls a read until taken
// synchronous reset clears control state and the crop registers; the frame store is not cleared
`default_nettype none

module mirror_border_frame_expander #(
   parameter int SRC_WIDTH  = 640,
   parameter int SRC_HEIGHT = 480,
   parameter int BORDER     = 100
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // pos_col [9:0], pos_row [19:10], tv_pixel [27:20], ir_pixel [35:28], zero fill
   input  wire  [mbfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode [0]
   input  wire  [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // out_tv_pixel [7:0], out_ir_pixel [15:8]
   output logic [mbfe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // out_of_range [0]
   output logic [0:0]                        rsp_tuser,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [mbfe_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [mbfe_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mbfe_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int MAXDIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
   localparam int CW0    = $clog2(2 * MAXDIM + 2 * BORDER + 1);
   localparam int CW     = (CW0 > mbfe_pkg::POS_W) ? CW0 : mbfe_pkg::POS_W;

   mbfe_pkg::crop_cfg_type  crop;
   mbfe_pkg::dp_cmd_type    cmd;
   mbfe_pkg::dp_status_type status;

   mbfe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .crop        (crop)
   );

   mbfe_ctrl #(
      .STEPS (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbfe_datapath #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT),
      .BORDER     (BORDER),
      .CW         (CW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .crop       (crop),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // every frame store access lands inside the source frame, after the folds too
   a_access_in_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_write || cmd.mem_read) |-> status.in_src)
      else $error("frame store access outside the source frame");

   // one transaction in flight: an accept takes the controller out of idle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.out_oor) |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while pending");

   // an out-of-frame result carries zero pixels
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("out-of-frame result with nonzero pixels");

endmodule

`default_nettype wire

/* test/mirror_border_frame_expander_tb.sv */
// self-checking testbench for mirror_border_frame_expander: stream driver, stream monitor,
// apb crop window writes and a transaction-level predictor of stores and mirrored reads
// depends on mbfe_pkg and the mirror_border_frame_expander top level
`timescale 1ns / 100ps

module mirror_border_frame_expander_tb;

   localparam int SRC_W    = 640;
   localparam int SRC_H    = 480;
   localparam int BORDER   = 100;
   localparam int EXP_W    = SRC_W + 2 * BORDER;
   localparam int EXP_H    = SRC_H + 2 * BORDER;
   localparam int LAT_PAD  = 80;
   localparam int IDLE_MAX = 5000;
   localparam int PHASE_N  = 80;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [9:0] col;
      logic [9:0] row;
      logic [7:0] tv;
      logic [7:0] ir;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] tv;
      logic [7:0] ir;
      logic       oor;
   } pixel_rsp_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mbfe_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mbfe_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [mbfe_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mbfe_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mbfe_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   pixel_req_type          req_pending[$];
   pixel_rsp_type          expected_pixels[$];
   bit [15:0]              shadow_frame[int];   // predictor copy of the frame store
   bit                     filled[int];         // entries the stimulus has already written
   mbfe_pkg::crop_cfg_type model_crop;          // updated on accepted register writes
   mbfe_pkg::crop_cfg_type gen_crop;            // what the stimulus generator assumes
   int                     err_cnt = 0;
   int                     req_gap = 0;
   int                     rsp_stall = 0;
   int                     idle_cycles = 0;

   mirror_border_frame_expander #(
      .SRC_WIDTH (SRC_W),
      .SRC_HEIGHT(SRC_H),
      .BORDER    (BORDER)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // symmetric edge-repeating reflection of x into [lo, hi]
   function automatic int fold_line(int x, int lo, int hi);
      int span;
      int per;
      int m;
      span = hi - lo + 1;
      per  = 2 * span;
      m    = (x - lo) % per;
      if (m < 0) m += per;
      return (m < span) ? lo + m : lo + per - 1 - m;
   endfunction

   // expanded coordinate -> source coordinate inside the clamped crop window
   function automatic int src_coord(int e, int size, int first, int last);
      int f;
      int l;
      f = (first > size - 1) ? size - 1 : first;
      l = (last > size - 1) ? size - 1 : last;
      if (f > l) l = f;
      return fold_line(fold_line(e - BORDER, 0, size - 1), f, l);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
      err_cnt++;
   endtask

   task automatic predict_pixel(pixel_req_type it);
      pixel_rsp_type res;
      int            sr;
      int            sc;
      if (it.op == OP_STORE) begin
         if (it.col < SRC_W && it.row < SRC_H)
            shadow_frame[int'(it.row) * SRC_W + int'(it.col)] = {it.ir, it.tv};
      end else if (it.col >= EXP_W || it.row >= EXP_H) begin
         res = '{tv: 8'h00, ir: 8'h00, oor: 1'b1};
         expected_pixels.push_back(res);
      end else begin
         sr = src_coord(it.row, SRC_H, model_crop.first_row, model_crop.last_row);
         sc = src_coord(it.col, SRC_W, model_crop.first_col, model_crop.last_col);
         res.tv  = shadow_frame[sr * SRC_W + sc][7:0];
         res.ir  = shadow_frame[sr * SRC_W + sc][15:8];
         res.oor = 1'b0;
         expected_pixels.push_back(res);
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      pixel_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (req_pending.size() != 0) begin
            nxt = req_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0000, nxt.ir, nxt.tv, nxt.row, nxt.col};
            req_tuser  <= nxt.op;
            req_gap    <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_stall  <= pick_gap();
      end
   end

   // accepted requests and register writes feed the predictor
   always @(posedge clock) begin : req_monitor
      pixel_req_type it;
      if (!reset && req_tvalid && req_tready) begin
         it.op  = req_tuser[0];
         it.col = req_tdata[9:0];
         it.row = req_tdata[19:10];
         it.tv  = req_tdata[27:20];
         it.ir  = req_tdata[35:28];
         predict_pixel(it);
      end
      if (!reset && csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            mbfe_pkg::REG_FIRST_ROW:
               model_crop.first_row = csr_pwdata[mbfe_pkg::ROW_CFG_W-1:0];
            mbfe_pkg::REG_LAST_ROW:
               model_crop.last_row  = csr_pwdata[mbfe_pkg::ROW_CFG_W-1:0];
            mbfe_pkg::REG_FIRST_COL:
               model_crop.first_col = csr_pwdata[mbfe_pkg::COL_CFG_W-1:0];
            mbfe_pkg::REG_LAST_COL:
               model_crop.last_col  = csr_pwdata[mbfe_pkg::COL_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pixel_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.tv)
               report_mismatch("out_tv_pixel", rsp_tdata[7:0], want.tv);
            if (rsp_tdata[15:8] !== want.ir)
               report_mismatch("out_ir_pixel", rsp_tdata[15:8], want.ir);
            if (rsp_tuser[0] !== want.oor)
               report_mismatch("out_of_range", rsp_tuser[0], want.oor);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("timeout: no transaction for %0d cycles", IDLE_MAX);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [mbfe_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // upper pwdata bits are junk on purpose, the block keeps only the register width
   task automatic set_crop(int first_row, int last_row, int first_col, int last_col);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(mbfe_pkg::REG_FIRST_ROW, {junk[31:9], 9'(first_row)});
      write_csr(mbfe_pkg::REG_LAST_ROW, {junk[30:8], 9'(last_row)});
      write_csr(mbfe_pkg::REG_FIRST_COL, {junk[21:0], 10'(first_col)});
      write_csr(mbfe_pkg::REG_LAST_COL, {~junk[21:0], 10'(last_col)});
      gen_crop.first_row = 9'(first_row);
      gen_crop.last_row  = 9'(last_row);
      gen_crop.first_col = 10'(first_col);
      gen_crop.last_col  = 10'(last_col);
   endtask

   // sender holds off until the block has nothing left to answer
   task automatic wait_idle();
      while (req_pending.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   task automatic queue_store(int col, int row, int tv, int ir);
      pixel_req_type it;
      it = '{op: OP_STORE, col: 10'(col), row: 10'(row), tv: 8'(tv), ir: 8'(ir)};
      req_pending.push_back(it);
      if (col < SRC_W && row < SRC_H) filled[row * SRC_W + col] = 1'b1;
   endtask

   // a read whose source entry is still empty gets a store in front of it
   task automatic queue_read(int col, int row);
      pixel_req_type it;
      int            sr;
      int            sc;
      if (col < EXP_W && row < EXP_H) begin
         sr = src_coord(row, SRC_H, gen_crop.first_row, gen_crop.last_row);
         sc = src_coord(col, SRC_W, gen_crop.first_col, gen_crop.last_col);
         if (!filled.exists(sr * SRC_W + sc))
            queue_store(sc, sr, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      it = '{op: OP_READ, col: 10'(col), row: 10'(row), tv: 8'($urandom), ir: 8'($urandom)};
      req_pending.push_back(it);
   endtask

   function automatic int pick_axis(int size, int first, int last);
      int r;
      int v;
      r = $urandom_range(0, 9);
      case (r)
         0: v = $urandom_range(0, 1023);
         1: v = $urandom_range(size + 2 * BORDER - 2, size + 2 * BORDER + 1);
         2: v = $urandom_range(0, 2);
         3: v = BORDER + $urandom_range(0, 3) - 2;
         4: v = BORDER + size + $urandom_range(0, 3) - 2;
         5: v = BORDER + first + $urandom_range(0, 2) - 1;
         6: v = BORDER + last + $urandom_range(0, 2) - 1;
         default: v = $urandom_range(0, size + 2 * BORDER - 1);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v;
   endfunction

   task automatic run_random(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            queue_read(pick_axis(SRC_W, gen_crop.first_col, gen_crop.last_col),
                       pick_axis(SRC_H, gen_crop.first_row, gen_crop.last_row));
         end else if (r < 90) begin
            queue_store($urandom_range(0, SRC_W - 1), $urandom_range(0, SRC_H - 1),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (r < 95) begin
            queue_store($urandom_range(SRC_W, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         end else begin
            queue_store($urandom_range(0, 1023), $urandom_range(SRC_H, 1023),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      model_crop = '{first_row: mbfe_pkg::RST_FIRST_ROW, last_row: mbfe_pkg::RST_LAST_ROW,
                     first_col: mbfe_pkg::RST_FIRST_COL, last_col: mbfe_pkg::RST_LAST_COL};
      gen_crop   = model_crop;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: pixel extremes, frame corners, border seams, stores and reads off the frame
      queue_store(0, 0, 8'hff, 8'h00);
      queue_store(SRC_W - 1, SRC_H - 1, 8'h00, 8'hff);
      queue_store(SRC_W, 0, 8'haa, 8'h55);
      queue_store(0, SRC_H, 8'h55, 8'haa);
      queue_store(1023, 1023, 8'hff, 8'hff);
      queue_read(0, 0);
      queue_read(EXP_W - 1, EXP_H - 1);
      queue_read(BORDER - 1, BORDER - 1);
      queue_read(BORDER, BORDER);
      queue_read(BORDER + SRC_W - 1, BORDER + SRC_H - 1);
      queue_read(BORDER + SRC_W, BORDER + SRC_H);
      queue_read(EXP_W, 0);
      queue_read(0, EXP_H);
      queue_read(1023, 1023);
      queue_read(420, 340);
      wait_idle();

      // reset window, with one full drain in the middle
      run_random(PHASE_N / 2);
      wait_idle();
      run_random(PHASE_N / 2);
      wait_idle();

      set_crop(0, SRC_H - 1, 0, SRC_W - 1);     // whole source frame
      run_random(PHASE_N);
      wait_idle();
      set_crop(0, 0, 0, 0);                     // single pixel window
      run_random(PHASE_N);
      wait_idle();
      set_crop(511, 511, 1023, 1023);           // bounds past the frame get clamped
      run_random(PHASE_N);
      wait_idle();
      set_crop(300, 100, 500, 200);             // first above last collapses the window
      run_random(PHASE_N);
      wait_idle();
      set_crop(200, 203, 300, 302);             // narrow window, folds many times
      run_random(PHASE_N);
      wait_idle();
      repeat (2) begin
         set_crop($urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
         run_random(PHASE_N);
         wait_idle();
      end

      if (err_cnt == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* mirror_border_frame_expander.f */
hw/rtl/mbfe_pkg.sv
hw/rtl/mbfe_csr.sv
hw/rtl/mbfe_ctrl.sv
hw/rtl/mbfe_datapath.sv
hw/rtl/mirror_border_frame_expander.sv
test/mirror_border_frame_expander_tb.sv
